/* sv/pbaw_pkg.sv */
// Package: shared types, codes and saturating fixed-point helpers for the PID block.
`timescale 1ns / 1ps
`default_nettype none
package pbaw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W + 1;
  localparam int CFG_IDX_W = 4;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam prod_t ROUND_HALF = prod_t'(1) << (FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN       = 4'd0,
    REG_SETPOINT_WEIGHT = 4'd1,
    REG_DERIV_POLE      = 4'd2,
    REG_DERIV_GAIN      = 4'd3,
    REG_INTEGRAL_COEFF  = 4'd4,
    REG_TRACKING_COEFF  = 4'd5,
    REG_MAX_DRIVE       = 4'd6,
    REG_MIN_DRIVE       = 4'd7
  } reg_idx_e;

  // Sequencer states; the datapath also reads the state as its step code.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SW,
    ST_T,
    ST_KP,
    ST_DG,
    ST_KI,
    ST_PID,
    ST_V,
    ST_UV,
    ST_TC,
    ST_DONE,
    ST_CLR
  } state_e;

  typedef struct packed {
    logic   load;
    state_e step;
    logic   commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_req;
  } dp_stat_t;

  function automatic word_t sat33(input logic signed [DATA_W:0] v);
    word_t r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return sat33(s);
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    return sat33(s);
  endfunction

  // Rounded product already carries the half LSB; floor shift and saturate.
  function automatic word_t sat_prod(input prod_t p);
    prod_t s;
    word_t r;
    s = p >>> FRAC_BITS;
    if ((&s[PROD_W-1:DATA_W-1]) || !(|s[PROD_W-1:DATA_W-1])) begin
      r = s[DATA_W-1:0];
    end else begin
      r = s[PROD_W-1] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/pbaw_if.sv */
// Interfaces: input, result and configuration channels of the PID block.
`timescale 1ns / 1ps
`default_nettype none
interface pbaw_in_if;
  logic                  valid;
  logic                  ready;
  logic                  command;
  pbaw_pkg::word_t       measurement;
  pbaw_pkg::word_t       target;
  pbaw_pkg::word_t       feedforward;
  modport source (output valid, command, measurement, target, feedforward, input ready);
  modport sink   (input valid, command, measurement, target, feedforward, output ready);
endinterface

interface pbaw_out_if;
  logic            valid;
  logic            ready;
  pbaw_pkg::word_t drive;
  pbaw_pkg::word_t unclamped_drive;
  pbaw_pkg::word_t pid_sum;
  modport source (output valid, drive, unclamped_drive, pid_sum, input ready);
  modport sink   (input valid, drive, unclamped_drive, pid_sum, output ready);
endinterface

interface pbaw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pbaw_pkg::CFG_IDX_W-1:0]   index;
  pbaw_pkg::word_t                  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/pbaw_ctrl.sv */
// Controller: step sequencer and result-valid handling for the PID block.
`timescale 1ns / 1ps
`default_nettype none
module pbaw_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire pbaw_pkg::dp_stat_t stat_i,
  output pbaw_pkg::dp_cmd_t       cmd_o
);

  pbaw_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbaw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.step   = state_q;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      pbaw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = stat_i.clear_req ? pbaw_pkg::ST_CLR : pbaw_pkg::ST_SW;
        end
      end
      pbaw_pkg::ST_SW:  state_d = pbaw_pkg::ST_T;
      pbaw_pkg::ST_T:   state_d = pbaw_pkg::ST_KP;
      pbaw_pkg::ST_KP:  state_d = pbaw_pkg::ST_DG;
      pbaw_pkg::ST_DG:  state_d = pbaw_pkg::ST_KI;
      pbaw_pkg::ST_KI:  state_d = pbaw_pkg::ST_PID;
      pbaw_pkg::ST_PID: state_d = pbaw_pkg::ST_V;
      pbaw_pkg::ST_V:   state_d = pbaw_pkg::ST_UV;
      pbaw_pkg::ST_UV:  state_d = pbaw_pkg::ST_TC;
      pbaw_pkg::ST_TC:  state_d = pbaw_pkg::ST_DONE;
      pbaw_pkg::ST_DONE, pbaw_pkg::ST_CLR: begin
        // hold until the output register can take the beat
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d = pbaw_pkg::ST_IDLE;
        end
      end
      default: state_d = pbaw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == pbaw_pkg::ST_IDLE))
    else $error("input ready outside idle");
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> out_free)
    else $error("commit would overwrite a pending result");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while busy");
  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.commit))
    else $error("result valid without commit");

endmodule
`default_nettype wire

/* sv/pbaw_dp.sv */
// Datapath: configuration, controller state, shared rounding multiplier and result registers.
`timescale 1ns / 1ps
`default_nettype none
module pbaw_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pbaw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire pbaw_pkg::word_t                cfg_data_i,
  input  wire logic                           command_i,
  input  wire pbaw_pkg::word_t                measurement_i,
  input  wire pbaw_pkg::word_t                target_i,
  input  wire pbaw_pkg::word_t                feedforward_i,
  input  wire pbaw_pkg::dp_cmd_t              cmd_i,
  output pbaw_pkg::dp_stat_t                  stat_o,
  output pbaw_pkg::word_t                     drive_o,
  output pbaw_pkg::word_t                     unclamped_drive_o,
  output pbaw_pkg::word_t                     pid_sum_o
);

  pbaw_pkg::word_t kp_q, sw_q, pole_q, dg_q, ki_c_q, tc_q, max_q, min_q;
  pbaw_pkg::word_t integ_q, last_d_q, last_m_q;
  pbaw_pkg::word_t meas_q, tgt_q, ff_q;
  pbaw_pkg::word_t dm_q, err_q, t_q, d1_q, p_q, d_q, ki_q, pid_q, v_q, u_q, uv_q;
  pbaw_pkg::word_t drive_q, unc_q, sum_q;
  pbaw_pkg::prod_t prod_q, prod_d;
  pbaw_pkg::word_t op_a, op_b, r, v_s, u_s;
  logic signed [2*pbaw_pkg::DATA_W-1:0] mp;
  logic mul_en;

  assign stat_o.clear_req = command_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      sw_q   <= '0;
      pole_q <= '0;
      dg_q   <= '0;
      ki_c_q <= '0;
      tc_q   <= '0;
      max_q  <= pbaw_pkg::word_t'(1) <<< pbaw_pkg::FRAC_BITS;
      min_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pbaw_pkg::REG_PROP_GAIN:       kp_q   <= cfg_data_i;
        pbaw_pkg::REG_SETPOINT_WEIGHT: sw_q   <= cfg_data_i;
        pbaw_pkg::REG_DERIV_POLE:      pole_q <= cfg_data_i;
        pbaw_pkg::REG_DERIV_GAIN:      dg_q   <= cfg_data_i;
        pbaw_pkg::REG_INTEGRAL_COEFF:  ki_c_q <= cfg_data_i;
        pbaw_pkg::REG_TRACKING_COEFF:  tc_q   <= cfg_data_i;
        pbaw_pkg::REG_MAX_DRIVE:       max_q  <= cfg_data_i;
        pbaw_pkg::REG_MIN_DRIVE:       min_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    mul_en = 1'b1;
    case (cmd_i.step)
      pbaw_pkg::ST_SW: begin op_a = sw_q;   op_b = tgt_q;    end
      pbaw_pkg::ST_T:  begin op_a = pole_q; op_b = last_d_q; end
      pbaw_pkg::ST_KP: begin op_a = kp_q;   op_b = t_q;      end
      pbaw_pkg::ST_DG: begin op_a = dg_q;   op_b = dm_q;     end
      pbaw_pkg::ST_KI: begin op_a = ki_c_q; op_b = err_q;    end
      pbaw_pkg::ST_TC: begin op_a = tc_q;   op_b = uv_q;     end
      default:         mul_en = 1'b0;
    endcase
  end

  assign mp     = op_a * op_b;
  assign prod_d = {mp[2*pbaw_pkg::DATA_W-1], mp} + pbaw_pkg::ROUND_HALF;
  assign r      = pbaw_pkg::sat_prod(prod_q);

  // upper clamp first, then lower: inverted limits give min_drive
  always_comb begin
    v_s = pbaw_pkg::sadd(pid_q, ff_q);
    u_s = (v_s > max_q) ? max_q : v_s;
    u_s = (u_s < min_q) ? min_q : u_s;
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.load) begin
      meas_q <= measurement_i;
      tgt_q  <= target_i;
      ff_q   <= feedforward_i;
    end
    case (cmd_i.step)
      pbaw_pkg::ST_SW: begin
        dm_q  <= pbaw_pkg::ssub(meas_q, last_m_q);
        err_q <= pbaw_pkg::ssub(tgt_q, meas_q);
      end
      pbaw_pkg::ST_T:   t_q  <= pbaw_pkg::ssub(r, meas_q);
      pbaw_pkg::ST_KP:  d1_q <= r;
      pbaw_pkg::ST_DG:  p_q  <= r;
      pbaw_pkg::ST_KI:  d_q  <= pbaw_pkg::ssub(d1_q, r);
      pbaw_pkg::ST_PID: begin
        ki_q  <= r;
        pid_q <= pbaw_pkg::sadd(pbaw_pkg::sadd(p_q, d_q), integ_q);
      end
      pbaw_pkg::ST_V: begin
        v_q <= v_s;
        u_q <= u_s;
      end
      pbaw_pkg::ST_UV:  uv_q <= pbaw_pkg::ssub(u_q, v_q);
      pbaw_pkg::ST_DONE: begin
        if (cmd_i.commit) begin
          drive_q <= u_q;
          unc_q   <= v_q;
          sum_q   <= pid_q;
        end
      end
      pbaw_pkg::ST_CLR: begin
        if (cmd_i.commit) begin
          drive_q <= '0;
          unc_q   <= '0;
          sum_q   <= '0;
        end
      end
      default: ;
    endcase
  end

  // controller state carried across steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q  <= '0;
      last_d_q <= '0;
      last_m_q <= '0;
    end else begin
      case (cmd_i.step)
        pbaw_pkg::ST_V: integ_q <= pbaw_pkg::sadd(integ_q, ki_q);
        pbaw_pkg::ST_DONE: begin
          if (cmd_i.commit) begin
            integ_q  <= pbaw_pkg::sadd(integ_q, r);
            last_m_q <= meas_q;
            last_d_q <= d_q;
          end
        end
        pbaw_pkg::ST_CLR: begin
          if (cmd_i.commit) begin
            integ_q  <= '0;
            last_m_q <= '0;
            last_d_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign drive_o           = drive_q;
  assign unclamped_drive_o = unc_q;
  assign pid_sum_o         = sum_q;

endmodule
`default_nettype wire

/* sv/pid_backcalc_antiwindup.sv */
// Top level: PID step with setpoint weighting, filtered derivative and back-calculation.
// The block computes one discrete PID step per input beat in signed Q16.16 with saturating
// arithmetic and round-half-up products. A compute beat passes from acceptance through ten
// sequencer steps before its result stands in the output register; a clear beat passes
// through the clear step. The steps are set by the single shared 32x32 multiplier, which is
// used for six products in sequence, each registered before its result is used. One item
// is in work at a time: input ready is high only while the sequencer is idle, so a new
// beat is taken only after the previous one is through. The result sits in an output
// register, so the next beat may be accepted while the previous result still waits; the
// sequencer holds its last step until that register is free. Configuration writes are
// always ready and must only be issued while the block is idle; indices above 7 are
// dropped. A clear command zeroes the integrator, the previous measurement and the
// previous derivative and returns a result of all zeros.
`timescale 1ns / 1ps
`default_nettype none
module pid_backcalc_antiwindup (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pbaw_in_if.sink    in_i,
  pbaw_out_if.source out_o,
  pbaw_cfg_if.sink   cfg_i
);

  pbaw_pkg::dp_cmd_t  cmd;
  pbaw_pkg::dp_stat_t stat;

  // configuration never stalls
  assign cfg_i.ready = 1'b1;

  pbaw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pbaw_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .command_i         (in_i.command),
    .measurement_i     (in_i.measurement),
    .target_i          (in_i.target),
    .feedforward_i     (in_i.feedforward),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .drive_o           (out_o.drive),
    .unclamped_drive_o (out_o.unclamped_drive),
    .pid_sum_o         (out_o.pid_sum)
  );

endmodule
`default_nettype wire
